>>> rtl/encoder_and_button_events_macros.svh
// assertion macros for the encoder and button event block
// used by the queue and back-end modules; no other dependencies
`ifndef ENCODER_AND_BUTTON_EVENTS_MACROS_SVH
`define ENCODER_AND_BUTTON_EVENTS_MACROS_SVH
`ifndef ASSERT_OFF
`define EABE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define EABE_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define EABE_ASSERT(lbl, clk, rst, prop, msg)
`define EABE_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

>>> rtl/eabe_pkg.sv
// shared types, constants and the quadrature table for the event block
// no dependencies
`default_nettype none
package eabe_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [3:0]  QUAD_INDEX_MASK   = 4'hF;
   localparam logic [7:0]  CLICK_MAX         = 8'd255;
   localparam logic [1:0]  PHASES_RESET      = 2'b11;
   localparam logic [6:0]  DETENT_RESET      = 7'd4;
   localparam logic [15:0] DEBOUNCE_RESET    = 16'd50;
   localparam logic [15:0] LONG_PRESS_RESET  = 16'd800;
   localparam logic [15:0] CLICK_GAP_RESET   = 16'd350;

   typedef enum logic [1:0] {
      CSR_DETENT     = 2'd0,
      CSR_DEBOUNCE   = 2'd1,
      CSR_LONG_PRESS = 2'd2,
      CSR_CLICK_GAP  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic        phase_a;
      logic        phase_b;
      logic        switch_level;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic signed [1:0] rotation;
      logic [7:0]        click_count;
      logic              long_press;
   } rsp_type;

   typedef struct packed {
      logic signed [1:0] step;
      logic              switch_level;
      logic [31:0]       now_ms;
   } item_type;

   typedef struct packed {
      logic [6:0]  transitions_per_detent;
      logic [15:0] debounce_time;
      logic [15:0] long_press_time;
      logic [15:0] click_gap_time;
   } cfg_type;

   function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
      logic signed [1:0] s;
      case (idx)
         4'd1, 4'd7, 4'd8, 4'd14:  s = -2'sd1;
         4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
         default:                  s = 2'sd0;
      endcase
      return s;
   endfunction

endpackage
`default_nettype wire

>>> rtl/eabe_front.sv
// front end: accepts polls and decodes the quadrature step
// depends on eabe_pkg
`default_nettype none
module eabe_front
   import eabe_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   input  wire req_type  req_data,
   input  wire logic     q_full,
   output logic          push,
   output item_type      push_item
);

   logic [1:0] prev_phases_ff;
   logic [1:0] prev_phases_in;
   logic [1:0] phases;

   always_comb begin
      phases            = {req_data.phase_a, req_data.phase_b};
      push              = req_valid && !q_full;
      prev_phases_in    = push ? phases : prev_phases_ff;
      push_item.step    = quad_step({prev_phases_ff, phases} & QUAD_INDEX_MASK);
      push_item.switch_level = req_data.switch_level;
      push_item.now_ms  = req_data.now_ms;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_phases_ff <= PHASES_RESET;
      end else begin
         prev_phases_ff <= prev_phases_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/eabe_queue.sv
// short queue between front and back ends
// depends on eabe_pkg and the assertion macros
`default_nettype none
`include "encoder_and_button_events_macros.svh"
module eabe_queue
   import eabe_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   input  wire logic     pop,
   output logic          full,
   output logic          head_valid,
   output item_type      head_item
);

   item_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QCNT_W-1:0] FULL_CNT = QCNT_W'(QUEUE_DEPTH);

   always_comb begin
      full       = (count_ff == FULL_CNT);
      head_valid = (count_ff != '0);
      head_item  = entry_ff[rd_ptr_ff];
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   `EABE_NEVER(a_no_overflow, clock, reset, push && full, "push into full queue")
   `EABE_NEVER(a_no_underflow, clock, reset, pop && !head_valid, "pop from empty queue")
   `EABE_NEVER(a_count_range, clock, reset, count_ff > FULL_CNT, "queue count out of range")

endmodule
`default_nettype wire

>>> rtl/eabe_back.sv
// back end: detent accumulation, debounce, click and long-press logic
// depends on eabe_pkg and the assertion macros
`default_nettype none
`include "encoder_and_button_events_macros.svh"
module eabe_back
   import eabe_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire logic     head_valid,
   input  wire item_type head_item,
   output logic          pop,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output rsp_type       rsp_data
);

   logic signed [7:0] acc_ff, acc_in;
   logic              raw_last_ff, raw_last_in;
   logic [31:0]       raw_time_ff, raw_time_in;
   logic              stable_ff, stable_in;
   logic [31:0]       press_time_ff, press_time_in;
   logic              lp_done_ff, lp_done_in;
   logic [7:0]        pending_ff, pending_in;
   logic [31:0]       release_time_ff, release_time_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic signed [8:0] sum;
   logic signed [8:0] lim;
   logic [31:0]       now;
   logic              raw;
   logic              raw_chg;
   logic [31:0]       db_diff, press_diff, rel_diff;
   logic              stable_upd, press_set, rel_set;

   always_comb begin
      pop  = head_valid && (!rsp_valid_ff || !rsp_stall);
      now  = head_item.now_ms;
      raw  = head_item.switch_level;

      acc_in          = acc_ff;
      raw_last_in     = raw_last_ff;
      raw_time_in     = raw_time_ff;
      stable_in       = stable_ff;
      press_time_in   = press_time_ff;
      lp_done_in      = lp_done_ff;
      pending_in      = pending_ff;
      release_time_in = release_time_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;

      // detent accumulation
      sum = $signed({acc_ff[7], acc_ff}) + $signed({{7{head_item.step[1]}}, head_item.step});
      lim = $signed({2'b00, cfg.transitions_per_detent});
      rsp_in.rotation = 2'sd0;
      if (head_item.step != 2'sd0) begin
         if (sum >= lim) begin
            acc_in          = '0;
            rsp_in.rotation = 2'sd1;
         end else if (sum <= -lim) begin
            acc_in          = '0;
            rsp_in.rotation = -2'sd1;
         end else begin
            acc_in = sum[7:0];
         end
      end

      // debounce
      raw_chg = (raw != raw_last_ff);
      if (raw_chg) begin
         raw_last_in = raw;
         raw_time_in = now;
      end
      db_diff    = raw_chg ? 32'd0 : now - raw_time_ff;
      stable_upd = (db_diff > {16'd0, cfg.debounce_time}) && (raw != stable_ff);
      press_set  = stable_upd && !raw;
      rel_set    = stable_upd && raw && !lp_done_ff;
      if (stable_upd) begin
         stable_in = raw;
      end
      if (press_set) begin
         press_time_in = now;
         lp_done_in    = 1'b0;
      end
      if (rel_set) begin
         if (pending_ff != CLICK_MAX) begin
            pending_in = pending_ff + 8'd1;
         end
         release_time_in = now;
      end

      // long press
      press_diff = press_set ? 32'd0 : now - press_time_ff;
      rsp_in.long_press = 1'b0;
      if (!stable_in && !lp_done_in && (press_diff >= {16'd0, cfg.long_press_time})) begin
         lp_done_in        = 1'b1;
         pending_in        = '0;
         rsp_in.long_press = 1'b1;
      end

      // click run end
      rel_diff = rel_set ? 32'd0 : now - release_time_ff;
      rsp_in.click_count = '0;
      if ((pending_in != '0) && (rel_diff >= {16'd0, cfg.click_gap_time})) begin
         rsp_in.click_count = pending_in;
         pending_in         = '0;
      end

      if (!pop) begin
         acc_in          = acc_ff;
         raw_last_in     = raw_last_ff;
         raw_time_in     = raw_time_ff;
         stable_in       = stable_ff;
         press_time_in   = press_time_ff;
         lp_done_in      = lp_done_ff;
         pending_in      = pending_ff;
         release_time_in = release_time_ff;
         rsp_in          = rsp_ff;
      end else begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff          <= '0;
         raw_last_ff     <= 1'b1;
         raw_time_ff     <= '0;
         stable_ff       <= 1'b1;
         press_time_ff   <= '0;
         lp_done_ff      <= 1'b0;
         pending_ff      <= '0;
         release_time_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         acc_ff          <= acc_in;
         raw_last_ff     <= raw_last_in;
         raw_time_ff     <= raw_time_in;
         stable_ff       <= stable_in;
         press_time_ff   <= press_time_in;
         lp_done_ff      <= lp_done_in;
         pending_ff      <= pending_in;
         release_time_ff <= release_time_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `EABE_NEVER(a_lp_no_clicks, clock, reset, rsp_valid_ff && rsp_ff.long_press && (rsp_ff.click_count != '0), "long press and clicks in one beat")
   `EABE_NEVER(a_rot_code, clock, reset, rsp_valid_ff && (rsp_ff.rotation == -2'sd2), "bad rotation code")
   `EABE_ASSERT(a_lp_pressed, clock, reset, (pop && rsp_in.long_press) |=> (!stable_ff && lp_done_ff), "long press without held state")

endmodule
`default_nettype wire

>>> rtl/encoder_and_button_events.sv
// top level: config registers, front end, queue and back end
// depends on eabe_pkg, eabe_front, eabe_queue, eabe_back
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_type (phases, switch, now_ms)
//   rsp      out        rsp_valid/rsp_stall   rsp_type (rotation, clicks, long press)
//   csr      in         csr_we                csr_index, csr_wdata
//
// one poll per cycle sustained while rsp does not stall; a taken poll reaches rsp
// through the two-entry queue and the output register of the back end
// req_stall rises only when the queue holds two beats, i.e. rsp has stalled
// synchronous reset clears all event state and loads the register defaults
`default_nettype none
module encoder_and_button_events
   import eabe_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [1:0]            csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   logic     q_full, push, pop, head_valid;
   item_type push_item, head_item;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_DETENT:     cfg_in.transitions_per_detent = csr_wdata[6:0];
            CSR_DEBOUNCE:   cfg_in.debounce_time          = csr_wdata;
            CSR_LONG_PRESS: cfg_in.long_press_time        = csr_wdata;
            CSR_CLICK_GAP:  cfg_in.click_gap_time         = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.transitions_per_detent <= DETENT_RESET;
         cfg_ff.debounce_time          <= DEBOUNCE_RESET;
         cfg_ff.long_press_time        <= LONG_PRESS_RESET;
         cfg_ff.click_gap_time         <= CLICK_GAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = q_full;

   eabe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (push),
      .push_item (push_item)
   );

   eabe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   eabe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

>>> tb/encoder_and_button_events_test.sv
// self-checking testbench for encoder_and_button_events: polls with encoder phases,
// switch level and timestamps, each response beat checked against a local prediction
// depends on eabe_pkg and the encoder_and_button_events top level
module encoder_and_button_events_test;
   timeunit 1ns;
   timeprecision 1ps;
   import eabe_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [1:0]            csr_index = CSR_DETENT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   encoder_and_button_events u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predicted register copies and event state
   logic [6:0]  detent_cfg = DETENT_RESET;
   logic [15:0] debounce_cfg = DEBOUNCE_RESET;
   logic [15:0] long_cfg = LONG_PRESS_RESET;
   logic [15:0] gap_cfg = CLICK_GAP_RESET;

   logic [1:0]  last_phases = PHASES_RESET;
   int          step_sum = 0;
   logic        raw_last = 1'b1;
   logic [31:0] raw_changed_at = '0;
   logic        sw_stable = 1'b1;
   logic [31:0] press_at = '0;
   logic        long_done = 1'b0;
   int unsigned clicks_pending = 0;
   logic [31:0] released_at = '0;

   int quad_table [0:15] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};

   req_type     polls_pending [$];
   rsp_type     events_expected [$];
   int unsigned polls_queued = 0;
   int unsigned polls_taken = 0;
   int unsigned mismatch_count = 0;
   logic        req_took = 1'b0;
   rsp_type     want;

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;

   logic [1:0]  gen_phases = 2'b11;
   logic [31:0] gen_time = '0;
   bit          gen_fwd = 1'b1;
   logic        gen_sw = 1'b1;
   int unsigned gen_scale = 16;

   function automatic rsp_type predict_poll(input req_type p);
      rsp_type     r;
      int          s;
      logic [1:0]  ph;
      logic [31:0] elapsed;
      r = '0;
      ph = {p.phase_a, p.phase_b};
      s = quad_table[{last_phases, ph}];
      last_phases = ph;
      if (s != 0) begin
         step_sum += s;
         if (step_sum >= int'(detent_cfg)) begin
            step_sum = 0;
            r.rotation = 2'sd1;
         end else if (step_sum <= -int'(detent_cfg)) begin
            step_sum = 0;
            r.rotation = -2'sd1;
         end
      end
      if (p.switch_level != raw_last) begin
         raw_last = p.switch_level;
         raw_changed_at = p.now_ms;
      end
      elapsed = p.now_ms - raw_changed_at;
      if (elapsed > {16'd0, debounce_cfg} && p.switch_level != sw_stable) begin
         sw_stable = p.switch_level;
         if (!sw_stable) begin
            press_at = p.now_ms;
            long_done = 1'b0;
         end else if (!long_done) begin
            if (clicks_pending < 255) clicks_pending++;
            released_at = p.now_ms;
         end
      end
      elapsed = p.now_ms - press_at;
      if (!sw_stable && !long_done && elapsed >= {16'd0, long_cfg}) begin
         long_done = 1'b1;
         clicks_pending = 0;
         r.long_press = 1'b1;
      end
      elapsed = p.now_ms - released_at;
      if (clicks_pending > 0 && elapsed >= {16'd0, gap_cfg}) begin
         r.click_count = clicks_pending[7:0];
         clicks_pending = 0;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      req_took = !reset && req_valid && !req_stall;
      if (req_took) begin
         events_expected.push_back(predict_poll(req_data));
         polls_taken++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (events_expected.size() == 0) begin
            $display("%0t unexpected rsp beat: got rot=%0d clicks=%0d long=%0b", $time,
                     $signed(rsp_data.rotation), rsp_data.click_count, rsp_data.long_press);
            mismatch_count++;
         end else begin
            want = events_expected.pop_front();
            if (rsp_data.rotation !== want.rotation) begin
               $display("%0t rotation mismatch: expected %0d, got %0d", $time,
                        $signed(want.rotation), $signed(rsp_data.rotation));
               mismatch_count++;
            end
            if (rsp_data.click_count !== want.click_count) begin
               $display("%0t click_count mismatch: expected %0d, got %0d", $time,
                        want.click_count, rsp_data.click_count);
               mismatch_count++;
            end
            if (rsp_data.long_press !== want.long_press) begin
               $display("%0t long_press mismatch: expected %0b, got %0b", $time,
                        want.long_press, rsp_data.long_press);
               mismatch_count++;
            end
         end
      end
   end

   // req driver: next beat only once the current one is taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (polls_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data <= polls_pending.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   task automatic queue_poll(input logic a, input logic b, input logic sw,
                             input logic [31:0] t);
      req_type p;
      p.phase_a = a;
      p.phase_b = b;
      p.switch_level = sw;
      p.now_ms = t;
      polls_pending.push_back(p);
      polls_queued++;
   endtask

   function automatic logic [1:0] turn(input logic [1:0] ph, input bit fwd);
      case (ph)
         2'b11:   return fwd ? 2'b01 : 2'b10;
         2'b01:   return fwd ? 2'b00 : 2'b11;
         2'b00:   return fwd ? 2'b10 : 2'b01;
         default: return fwd ? 2'b11 : 2'b00;
      endcase
   endfunction

   task automatic random_poll();
      int unsigned r;
      logic [1:0]  ph;
      logic        sw;
      logic [31:0] dt;
      r = $urandom_range(99);
      if (r < 8) begin
         ph = 2'($urandom_range(3));
         sw = 1'($urandom_range(1));
         if ($urandom_range(1)) gen_time = $urandom();
         else gen_time += $urandom_range(0, 8 * gen_scale);
         gen_phases = ph;
         queue_poll(ph[1], ph[0], sw, gen_time);
      end else begin
         if ($urandom_range(49) == 0) gen_fwd = !gen_fwd;
         r = $urandom_range(99);
         if (r < 40) gen_phases = turn(gen_phases, gen_fwd);
         else if (r < 50) gen_phases = turn(gen_phases, !gen_fwd);
         if ($urandom_range(3) == 0) gen_sw = !gen_sw;
         sw = ($urandom_range(9) == 0) ? !gen_sw : gen_sw;
         r = $urandom_range(9);
         if (r < 7) dt = $urandom_range(0, gen_scale);
         else if (r < 9) dt = $urandom_range(0, 3);
         else dt = $urandom_range(0, 4 * gen_scale);
         gen_time += dt;
         queue_poll(gen_phases[1], gen_phases[0], sw, gen_time);
      end
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_DETENT:     detent_cfg = val[6:0];
         CSR_DEBOUNCE:   debounce_cfg = val;
         CSR_LONG_PRESS: long_cfg = val;
         default:        gap_cfg = val;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(input logic [15:0] det, input logic [15:0] deb,
                            input logic [15:0] lpt, input logic [15:0] gap);
      write_reg(CSR_DETENT, det);
      write_reg(CSR_DEBOUNCE, deb);
      write_reg(CSR_LONG_PRESS, lpt);
      write_reg(CSR_CLICK_GAP, gap);
   endtask

   function automatic logic [15:0] pick_ms();
      case ($urandom_range(5))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         5:       return 16'($urandom_range(0, 65535));
         default: return 16'($urandom_range(1, 1000));
      endcase
   endfunction

   task automatic set_idle(input int unsigned mode);
      case (mode)
         0: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         1: begin
            send_idle_pct = 67;
            recv_stall_pct = 0;
         end
         2: begin
            send_idle_pct = 0;
            recv_stall_pct = 67;
         end
         default: begin
            send_idle_pct = 25;
            recv_stall_pct = 25;
         end
      endcase
   endtask

   task automatic drain();
      while (polls_taken != polls_queued || events_expected.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int stage;
      int i;
      int j;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: timestamp extremes, both turn directions, invalid jumps
      set_idle(3);
      queue_poll(1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
      queue_poll(1'b0, 1'b1, 1'b1, 32'd0);
      queue_poll(1'b0, 1'b0, 1'b1, 32'd1);
      queue_poll(1'b1, 1'b0, 1'b1, 32'd2);
      queue_poll(1'b1, 1'b1, 1'b1, 32'd3);
      queue_poll(1'b1, 1'b0, 1'b1, 32'd4);
      queue_poll(1'b0, 1'b0, 1'b1, 32'd5);
      queue_poll(1'b0, 1'b1, 1'b1, 32'd6);
      queue_poll(1'b1, 1'b1, 1'b1, 32'd7);
      queue_poll(1'b0, 1'b0, 1'b1, 32'd8);
      queue_poll(1'b0, 1'b0, 1'b1, 32'd9);
      queue_poll(1'b1, 1'b1, 1'b1, 32'd10);
      // bouncy press, release, single click out after the gap
      queue_poll(1'b1, 1'b1, 1'b0, 32'd1000);
      queue_poll(1'b1, 1'b1, 1'b1, 32'd1005);
      queue_poll(1'b1, 1'b1, 1'b0, 32'd1010);
      queue_poll(1'b1, 1'b1, 1'b0, 32'd1100);
      queue_poll(1'b1, 1'b1, 1'b1, 32'd1200);
      queue_poll(1'b1, 1'b1, 1'b1, 32'd1300);
      queue_poll(1'b1, 1'b1, 1'b1, 32'd1700);
      // long hold, then release that must not count
      queue_poll(1'b1, 1'b1, 1'b0, 32'd2000);
      queue_poll(1'b1, 1'b1, 1'b0, 32'd2100);
      queue_poll(1'b1, 1'b1, 1'b0, 32'd2900);
      queue_poll(1'b1, 1'b1, 1'b1, 32'd3000);
      queue_poll(1'b1, 1'b1, 1'b1, 32'd3100);
      queue_poll(1'b1, 1'b1, 1'b1, 32'd3600);
      drain();

      for (stage = 0; stage < 14; stage++) begin
         case (stage)
            0:       configure(16'd1, 16'd0, 16'd0, 16'd0);
            1:       configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            2:       configure(16'd0, pick_ms(), pick_ms(), pick_ms());
            3:       configure(16'd4, 16'd50, 16'd800, 16'd350);
            default: configure(16'($urandom_range(1) ? $urandom_range(1, 6)
                                                     : $urandom_range(0, 127)),
                               pick_ms(), pick_ms(), pick_ms());
         endcase
         set_idle(stage % 4);
         gen_scale = (int'(debounce_cfg) + int'(long_cfg) + int'(gap_cfg)) / 6 + 2;
         if ($urandom_range(3) == 0) gen_time = 32'hFFFF_FFFF - $urandom_range(0, 20 * gen_scale);
         else gen_time = $urandom();
         repeat (25) random_poll();
         drain();
      end

      // click saturation with a long steady spin against the largest threshold
      configure(16'h007F, 16'd0, 16'hFFFF, 16'hFFFF);
      set_idle(3);
      gen_time = $urandom();
      for (i = 0; i < 257; i++) begin
         for (j = 0; j < 4; j++) begin
            gen_phases = turn(gen_phases, i < 128);
            queue_poll(gen_phases[1], gen_phases[0], j >= 2, gen_time);
            gen_time += 1;
         end
      end
      queue_poll(gen_phases[1], gen_phases[0], 1'b1, gen_time + 32'd70000);
      drain();

      repeat (8) @(negedge clock);
      if (mismatch_count == 0 && events_expected.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
